/* rtl/emst_pkg.sv */
// Shared types and constants for the Euclidean spanning tree block.
// No dependencies.
package emst_pkg;

  localparam int COORD_W = 24;
  localparam int DIST_W = 25;
  localparam int SQ_W = 2 * DIST_W;
  localparam int WEIGHT_W = 32;
  localparam int USED_W = 8;
  localparam int DEFAULT_MAX_POINTS = 128;

  typedef enum logic [1:0] {
    DU_IDLE,
    DU_SQX,
    DU_SQY,
    DU_ROOT
  } du_state_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_FETCHC,
    ST_RD,
    ST_WAITRD,
    ST_CALC,
    ST_NEXT,
    ST_ADD,
    ST_OUT
  } top_state_t;

endpackage

/* rtl/emst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module emst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/emst_dist.sv */
// Distance unit: one shared multiplier squares dx and dy, then a
// bit-per-cycle square root. Depends on emst_pkg.
module emst_dist import emst_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [COORD_W-1:0]  ax,
  input  logic signed [COORD_W-1:0]  ay,
  input  logic signed [COORD_W-1:0]  bx,
  input  logic signed [COORD_W-1:0]  by,
  output logic                       done,
  output logic [DIST_W-1:0]          span
);

  localparam int STEP_W = $clog2(DIST_W);

  du_state_t state, state_next;
  logic [COORD_W-1:0] ux, uy;
  logic [SQ_W-1:0] acc;
  logic [DIST_W+1:0] rem;
  logic [DIST_W-1:0] root;
  logic [STEP_W-1:0] step;
  logic [COORD_W:0] dxw, dyw;
  logic [COORD_W-1:0] mul_op;
  logic [2*COORD_W-1:0] prod;
  logic [DIST_W+1:0] rem_sh, trial;

  assign dxw = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
  assign dyw = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
  assign mul_op = (state == DU_SQX) ? ux : uy;
  assign prod = mul_op * mul_op;
  assign rem_sh = {rem[DIST_W-1:0], acc[SQ_W-1 -: 2]};
  assign trial = {root, 2'b01};
  assign span = {root[DIST_W-2:0], rem_sh >= trial};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done = 1'b0;
    unique case (state)
      DU_IDLE: if (start) state_next = DU_SQX;
      DU_SQX:  state_next = DU_SQY;
      DU_SQY:  state_next = DU_ROOT;
      DU_ROOT: begin
        if (step == STEP_W'(DIST_W - 1)) begin
          state_next = DU_IDLE;
          done = 1'b1;
        end
      end
      default: state_next = DU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      DU_IDLE: begin
        ux <= dxw[COORD_W] ? COORD_W'(-dxw) : dxw[COORD_W-1:0];
        uy <= dyw[COORD_W] ? COORD_W'(-dyw) : dyw[COORD_W-1:0];
        rem <= '0;
        root <= '0;
        step <= '0;
      end
      DU_SQX: acc <= SQ_W'(prod);
      DU_SQY: acc <= acc + SQ_W'(prod);
      DU_ROOT: begin
        acc <= acc << 2;
        step <= step + 1'b1;
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          root <= {root[DIST_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          root <= {root[DIST_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/euclidean_mst_kruskal.sv */
// Top level: point store, nearest-distance table and spanning tree sequencer.
// Depends on emst_pkg, emst_ram and emst_dist.
//
// Points load at one beat per cycle. After the beat marked last, the block
// grows the minimum spanning tree one vertex at a time: each growth step
// sweeps all stored points, passing each point still outside the tree
// through the single distance unit, before the single result beat.
// Input is not ready during that time. The weight is unique, so it matches
// any Kruskal ordering of equal edges.
module euclidean_mst_kruskal import emst_pkg::*; #(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic                      last_point,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [WEIGHT_W-1:0]       tree_weight,
  output logic [USED_W-1:0]         points_used,
  output logic                      overflow_flag
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  top_state_t state, state_next;
  logic [CW-1:0] count, added;
  logic dropped;
  logic [WEIGHT_W-1:0] sum;
  logic [IW-1:0] k, bidx, pt_raddr, dt_waddr;
  logic [DIST_W-1:0] best, old_dist;
  logic signed [COORD_W-1:0] cx, cy;
  logic [2*COORD_W-1:0] pt_rdata;
  logic [DIST_W:0] dt_rdata, dt_wdata;
  logic dt_we, pt_we, du_start, du_done;
  logic [DIST_W-1:0] du_dist, new_dist;
  logic [WEIGHT_W:0] sum_wide;

  assign in_ready = (state == ST_LOAD);
  assign out_valid = (state == ST_OUT);
  assign tree_weight = sum;
  assign points_used = USED_W'(count);
  assign overflow_flag = dropped;
  assign new_dist = (du_dist < old_dist) ? du_dist : old_dist;
  assign sum_wide = {1'b0, sum} + (WEIGHT_W + 1)'(best);
  assign pt_we = in_valid && in_ready && (count < CW'(MAX_POINTS));

  emst_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POINTS)) u_points (
    .clk(clk), .we(pt_we), .waddr(count[IW-1:0]), .wdata({point_x, point_y}),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  emst_ram #(.WIDTH(DIST_W + 1), .DEPTH(MAX_POINTS)) u_near (
    .clk(clk), .we(dt_we), .waddr(dt_waddr), .wdata(dt_wdata),
    .raddr(k), .rdata(dt_rdata)
  );

  emst_dist u_dist (
    .clk(clk), .rst(rst), .start(du_start),
    .ax(cx), .ay(cy),
    .bx(pt_rdata[2*COORD_W-1:COORD_W]), .by(pt_rdata[COORD_W-1:0]),
    .done(du_done), .span(du_dist)
  );

  always_comb begin
    state_next = state;
    pt_raddr = k;
    dt_we = 1'b0;
    dt_waddr = k;
    dt_wdata = {1'b0, {DIST_W{1'b1}}};
    du_start = 1'b0;
    unique case (state)
      ST_LOAD: begin
        dt_we = pt_we;
        dt_waddr = count[IW-1:0];
        if (in_valid && last_point) state_next = ST_START;
      end
      ST_START: begin
        pt_raddr = '0;
        dt_we = 1'b1;
        dt_waddr = '0;
        dt_wdata = {1'b1, {DIST_W{1'b0}}};
        state_next = (count == CW'(1)) ? ST_OUT : ST_FETCHC;
      end
      ST_FETCHC: state_next = ST_RD;
      ST_RD: state_next = ST_WAITRD;
      ST_WAITRD: begin
        if (dt_rdata[DIST_W]) begin
          state_next = ST_NEXT;
        end else begin
          du_start = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (du_done) begin
          dt_we = 1'b1;
          dt_wdata = {1'b0, new_dist};
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: begin
        state_next = ({{(CW - IW){1'b0}}, k} == count - 1'b1) ? ST_ADD : ST_RD;
      end
      ST_ADD: begin
        pt_raddr = bidx;
        dt_we = 1'b1;
        dt_waddr = bidx;
        dt_wdata = {1'b1, {DIST_W{1'b0}}};
        state_next = (added + 1'b1 == count) ? ST_OUT : ST_FETCHC;
      end
      ST_OUT: if (out_ready) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      dropped <= 1'b0;
      sum <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: begin
          if (in_valid) begin
            if (count < CW'(MAX_POINTS)) count <= count + 1'b1;
            else dropped <= 1'b1;
          end
        end
        ST_ADD: sum <= sum_wide[WEIGHT_W] ? '1 : sum_wide[WEIGHT_W-1:0];
        ST_OUT: begin
          if (out_ready) begin
            count <= '0;
            dropped <= 1'b0;
            sum <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_START: added <= CW'(1);
      ST_FETCHC: begin
        cx <= pt_rdata[2*COORD_W-1:COORD_W];
        cy <= pt_rdata[COORD_W-1:0];
        k <= '0;
        best <= '1;
      end
      ST_WAITRD: old_dist <= dt_rdata[DIST_W-1:0];
      ST_CALC: begin
        if (du_done && new_dist < best) begin
          best <= new_dist;
          bidx <= k;
        end
      end
      ST_NEXT: k <= k + 1'b1;
      ST_ADD: added <= added + 1'b1;
      default: ;
    endcase
  end

endmodule

/* tb/tb_euclidean_mst_kruskal.sv */
// Self-checking testbench for euclidean_mst_kruskal: point sets in, tree weight beats out.
// Predicts each set's spanning tree weight with a Prim sweep; depends on emst_pkg.
module tb_euclidean_mst_kruskal;
  import emst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = DEFAULT_MAX_POINTS;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
    logic                      hold;
  } point_beat_t;

  typedef struct {
    logic [WEIGHT_W-1:0] weight;
    logic [USED_W-1:0]   used;
    logic                dropped;
  } tree_sum_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic last_point = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [WEIGHT_W-1:0] tree_weight;
  logic [USED_W-1:0] points_used;
  logic overflow_flag;

  point_beat_t pending_points[$];
  tree_sum_t expected_sums[$];
  logic signed [COORD_W-1:0] set_x[CAP];
  logic signed [COORD_W-1:0] set_y[CAP];
  int set_count = 0;
  logic set_dropped = 0;
  logic in_fire = 0;
  int sent = 0;
  int total_points = 0;
  int errors = 0;
  longint cycles = 0;

  euclidean_mst_kruskal u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .last_point(last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .tree_weight(tree_weight), .points_used(points_used), .overflow_flag(overflow_flag)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned pair_length(int i, int j);
    longint dx, dy;
    dx = longint'(set_x[i]) - longint'(set_x[j]);
    dy = longint'(set_y[i]) - longint'(set_y[j]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return int_sqrt(longint'(dx * dx + dy * dy));
  endfunction

  function automatic logic [WEIGHT_W-1:0] tree_length(int n);
    longint unsigned best[CAP];
    bit joined[CAP];
    longint unsigned total, d;
    int pick;
    total = 0;
    for (int i = 0; i < n; i++) begin
      joined[i] = 0;
      best[i] = '1;
    end
    best[0] = 0;
    for (int k = 0; k < n; k++) begin
      pick = -1;
      for (int i = 0; i < n; i++)
        if (!joined[i] && (pick < 0 || best[i] < best[pick])) pick = i;
      joined[pick] = 1;
      total += best[pick];
      for (int i = 0; i < n; i++)
        if (!joined[i]) begin
          d = pair_length(pick, i);
          if (d < best[i]) best[i] = d;
        end
    end
    if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
    return total[WEIGHT_W-1:0];
  endfunction

  task automatic add_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                           logic last, logic hold);
    point_beat_t p;
    p.x = x;
    p.y = y;
    p.last = last;
    p.hold = hold;
    pending_points.insert(pending_points.size(), p);
  endtask

  task automatic add_random_set(int n, int spread, logic hold);
    logic signed [COORD_W-1:0] x, y;
    for (int i = 0; i < n; i++) begin
      if (spread == 0) begin
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
      end else begin
        x = COORD_W'($urandom_range(2 * spread) - spread);
        y = COORD_W'($urandom_range(2 * spread) - spread);
      end
      add_point(x, y, i == n - 1, hold && i == 0);
    end
  endtask

  initial begin
    int n, mode;
    add_point(24'sh800000, 24'sh7FFFFF, 1, 0);
    add_point(24'sh7FFFFF, 24'sh7FFFFF, 0, 0);
    add_point(24'sh800000, 24'sh800000, 1, 0);
    add_point(24'sh000100, 24'sh000100, 0, 0);
    add_point(24'sh000100, 24'sh000100, 0, 0);
    add_point(24'sh000000, 24'sh000000, 1, 0);
    add_point(24'sh000000, 24'sh000000, 0, 1);
    add_point(24'sh000300, 24'sh000000, 0, 0);
    add_point(24'sh000000, 24'sh000400, 0, 0);
    add_point(-24'sh000300, 24'sh000000, 1, 0);
    for (int i = 0; i < CAP + 1; i++)
      add_point(COORD_W'($urandom_range(4000) - 2000), COORD_W'($urandom_range(4000) - 2000),
                i == CAP, 0);
    add_random_set(CAP + 3, 0, 0);
    for (int i = 0; i < 6; i++) add_random_set(3 + i, 0, 1);
    while (pending_points.size() < 950) begin
      mode = $urandom_range(99);
      n = (mode < 5) ? 1 : (mode < 10) ? $urandom_range(24, 11) : $urandom_range(10, 2);
      case ($urandom_range(3))
        0: add_random_set(n, 8, $urandom_range(19) == 0);
        1: add_random_set(n, 300, $urandom_range(19) == 0);
        default: add_random_set(n, 0, $urandom_range(19) == 0);
      endcase
    end
    total_points = pending_points.size();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    wait (pending_points.size() == 0 && !in_valid && expected_sums.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(negedge clk) begin
    int sender_idle, receiver_idle;
    sender_idle = (sent < total_points / 3) ? 29 : (sent < 2 * total_points / 3) ? 71 : 0;
    receiver_idle = (sent < total_points / 3) ? 71 : (sent < 2 * total_points / 3) ? 29 : 0;
    if (!rst) begin
      out_ready <= $urandom_range(99) >= receiver_idle;
      if (!in_valid || in_fire) begin
        if (pending_points.size() != 0 &&
            !(pending_points[0].hold && expected_sums.size() != 0) &&
            $urandom_range(99) >= sender_idle) begin
          point_x <= pending_points[0].x;
          point_y <= pending_points[0].y;
          last_point <= pending_points[0].last;
          void'(pending_points.pop_front());
          sent++;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tree_sum_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    in_fire <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      if (set_count < CAP) begin
        set_x[set_count] = point_x;
        set_y[set_count] = point_y;
        set_count++;
      end else begin
        set_dropped = 1;
      end
      if (last_point) begin
        want.weight = tree_length(set_count);
        want.used = set_count[USED_W-1:0];
        want.dropped = set_dropped;
        expected_sums.insert(expected_sums.size(), want);
        set_count = 0;
        set_dropped = 0;
      end
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected result beat weight=%0d used=%0d flag=%0b",
                 $time, tree_weight, points_used, overflow_flag);
        errors++;
      end else begin
        want = expected_sums.pop_front();
        if (tree_weight !== want.weight) begin
          $display("%0t: tree_weight expected %0d actual %0d", $time, want.weight, tree_weight);
          errors++;
        end
        if (points_used !== want.used) begin
          $display("%0t: points_used expected %0d actual %0d", $time, want.used, points_used);
          errors++;
        end
        if (overflow_flag !== want.dropped) begin
          $display("%0t: overflow_flag expected %0b actual %0b",
                   $time, want.dropped, overflow_flag);
          errors++;
        end
      end
    end
  end

endmodule
